[hdl/apd_pkg.sv]
// shared types and constants for the sound chip port decoder
// used by apd_core and ay_port_decoder_zx_cpc, no dependencies
`default_nettype none

package apd_pkg;

    typedef enum logic [1:0] {
        MODE_DETECT = 2'd0,
        MODE_ZX     = 2'd1,
        MODE_CPC    = 2'd2
    } mode_t;

    localparam logic [15:0] ZX_MASK         = 16'hC002;
    localparam logic [15:0] ZX_SELECT       = 16'hFFFD & ZX_MASK;
    localparam logic [15:0] ZX_DATA         = 16'hBFFD & ZX_MASK;
    localparam logic [7:0]  CPC_HIGH_MASK   = 8'h0B;
    localparam logic [7:0]  CPC_DATA_CODE   = 8'hF4 & CPC_HIGH_MASK;
    localparam logic [7:0]  CPC_SWITCH_CODE = 8'hF6 & CPC_HIGH_MASK;
    localparam logic [1:0]  SW_ADDRESS      = 2'd3;
    localparam logic [1:0]  SW_WRITE        = 2'd2;
    localparam logic [7:0]  REG_LIMIT       = 8'd14;
    localparam logic [7:0]  IDLE_BUS        = 8'hFF;

    localparam logic CFG_BEEPER_HIGH = 1'b0;
    localparam logic CFG_AUTO_FREQ   = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [15:0] port_address;
        logic [7:0]  data_byte;
        logic [7:0]  chip_read_byte;
    } item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        chip_read_strobe;
        logic        chip_write_strobe;
        logic [7:0]  chip_register;
        logic [7:0]  chip_write_value;
        logic        beeper_changed;
        logic [14:0] beeper_now;
        logic        clock_switch_event;
        logic [1:0]  machine_mode;
    } result_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  sel;
        logic [7:0]  pio_data;
        logic [1:0]  pio_switch;
        logic [14:0] beeper;
    } state_t;

endpackage

`default_nettype wire

[hdl/apd_core.sv]
// decode of one port access plus the decoder state and config registers
// depends on apd_pkg
`default_nettype none

module apd_core
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_we,
    input  wire logic            cfg_index,
    input  wire logic [14:0]     cfg_data,
    input  wire logic            advance,
    input  wire apd_pkg::item_t  item,
    output apd_pkg::result_t     result
);

    apd_pkg::state_t st_reg;
    apd_pkg::state_t st_next;
    logic [14:0]     beeper_high_reg;
    logic            auto_freq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg          <= '0;
            beeper_high_reg <= '0;
            auto_freq_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                st_reg <= st_next;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    apd_pkg::CFG_BEEPER_HIGH: beeper_high_reg <= cfg_data;
                    apd_pkg::CFG_AUTO_FREQ:   auto_freq_reg   <= cfg_data[0];
                    default:                  ;
                endcase
            end
        end
    end

    always_comb
    begin
        logic [15:0] zxsel;
        logic [7:0]  hi;
        logic        is_data;
        logic        is_switch;
        logic [7:0]  pd;
        logic [1:0]  ps;
        logic        pio_wr;
        logic [7:0]  pio_sel;
        logic        beep_hit;
        logic [14:0] beep_val;
        logic        beep_chg;
        logic        sel_ok;
        logic        rd_ok;

        zxsel     = item.port_address & apd_pkg::ZX_MASK;
        hi        = item.port_address[15:8] & apd_pkg::CPC_HIGH_MASK;
        is_data   = (hi == apd_pkg::CPC_DATA_CODE);
        is_switch = (hi == apd_pkg::CPC_SWITCH_CODE);
        sel_ok    = (st_reg.sel < apd_pkg::REG_LIMIT);

        // pio latches take the new byte first, then the commit looks at them
        pd      = is_data ? item.data_byte : st_reg.pio_data;
        ps      = is_switch ? item.data_byte[7:6] : st_reg.pio_switch;
        pio_sel = (ps == apd_pkg::SW_ADDRESS) ? pd : st_reg.sel;
        pio_wr  = (ps == apd_pkg::SW_WRITE) && sel_ok;

        // outside cpc mode, even-port writes drive the beeper from data bit 4
        beep_hit = !item.port_address[0];
        beep_val = item.data_byte[4] ? beeper_high_reg : 15'd0;
        beep_chg = beep_hit && (beep_val != st_reg.beeper);

        rd_ok = (st_reg.mode != apd_pkg::MODE_CPC) && (zxsel == apd_pkg::ZX_SELECT) && sel_ok;

        st_next = st_reg;
        result  = '0;
        result.read_data = apd_pkg::IDLE_BUS;

        if (!item.opcode)
        begin
            if (rd_ok)
            begin
                result.read_data        = item.chip_read_byte;
                result.chip_read_strobe = 1'b1;
            end
        end
        else
        begin
            unique case (st_reg.mode)
                apd_pkg::MODE_CPC:
                begin
                    if (is_data || is_switch)
                    begin
                        st_next.pio_data   = pd;
                        st_next.pio_switch = ps;
                        st_next.sel        = pio_sel;
                        result.chip_write_strobe = pio_wr;
                        result.chip_write_value  = pio_wr ? pd : 8'd0;
                    end
                end
                apd_pkg::MODE_ZX:
                begin
                    if (beep_chg)
                    begin
                        st_next.beeper = beep_val;
                    end
                    result.beeper_changed = beep_chg;
                    if (zxsel == apd_pkg::ZX_SELECT)
                    begin
                        st_next.sel = item.data_byte;
                    end
                    else if (zxsel == apd_pkg::ZX_DATA && sel_ok)
                    begin
                        result.chip_write_strobe = 1'b1;
                        result.chip_write_value  = item.data_byte;
                    end
                end
                default:
                begin
                    // detecting, and the unused code behaves the same
                    if (beep_chg)
                    begin
                        st_next.beeper = beep_val;
                    end
                    result.beeper_changed = beep_chg;
                    if (is_data || is_switch)
                    begin
                        st_next.pio_data   = pd;
                        st_next.pio_switch = ps;
                        st_next.sel        = pio_sel;
                        result.chip_write_strobe = pio_wr;
                        result.chip_write_value  = pio_wr ? pd : 8'd0;
                        // a committed write on the switch port locks to cpc
                        if (is_switch && pio_wr)
                        begin
                            st_next.mode   = apd_pkg::MODE_CPC;
                            st_next.beeper = 15'd0;
                            result.clock_switch_event = auto_freq_reg;
                        end
                    end
                    else if (zxsel == apd_pkg::ZX_SELECT)
                    begin
                        st_next.mode = apd_pkg::MODE_ZX;
                        st_next.sel  = item.data_byte;
                    end
                    else if (zxsel == apd_pkg::ZX_DATA && sel_ok)
                    begin
                        st_next.mode = apd_pkg::MODE_ZX;
                        result.chip_write_strobe = 1'b1;
                        result.chip_write_value  = item.data_byte;
                    end
                end
            endcase
        end

        result.chip_register = st_next.sel;
        result.beeper_now    = st_next.beeper;
        result.machine_mode  = st_next.mode;
    end

endmodule

`default_nettype wire

[hdl/ay_port_decoder_zx_cpc.sv]
// top level of the sound chip port decoder: input register, result register
// depends on apd_pkg and apd_core
//
// Usage: each request on the s_ side is one cpu i/o access (tuser = write
// flag, tdata = port, write byte, byte offered by the chip for its selected
// register). For every request one result leaves on the m_ side with the
// read value, chip strobes, selected register, beeper level, clock switch
// flag and the machine mode after the access.
// The request sits in the input register, then the decode runs into the
// result register, which drives m_tvalid. Throughput is one request per
// cycle while the receiver keeps m_tready high; the decode is a single
// pass of compare and select logic.
// When the receiver stalls the result register holds and the input register
// still takes one more request; after that s_tready drops until m_tready.
// Reset clears the valid flags of both stages, the config registers and
// all decoder state: auto-detect mode, register 0, pio latches 0, beeper 0.
// The config channel is always ready and should be written while idle.
`default_nettype none

module ay_port_decoder_zx_cpc
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // port_address, write_byte, chip_read_byte
    input  wire logic [0:0]  s_tuser,   // opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // read_data, chip_read_strobe, chip_write_strobe, chip_register,
    // chip_write_value, beeper_changed, beeper_now, clock_switch_event,
    // machine_mode, zero fill
    output logic [47:0]      m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [14:0] cfg_data
);

    logic              in_valid_reg;
    apd_pkg::item_t    in_item_reg;
    logic              out_valid_reg;
    apd_pkg::result_t  out_res_reg;
    apd_pkg::result_t  res;
    logic              advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.opcode         <= s_tuser[0];
            in_item_reg.port_address   <= s_tdata[15:0];
            in_item_reg.data_byte      <= s_tdata[23:16];
            in_item_reg.chip_read_byte <= s_tdata[31:24];
        end
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    apd_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .item      (in_item_reg),
        .result    (res)
    );

    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        m_tdata        = '0;
        m_tdata[7:0]   = out_res_reg.read_data;
        m_tdata[8]     = out_res_reg.chip_read_strobe;
        m_tdata[9]     = out_res_reg.chip_write_strobe;
        m_tdata[17:10] = out_res_reg.chip_register;
        m_tdata[25:18] = out_res_reg.chip_write_value;
        m_tdata[26]    = out_res_reg.beeper_changed;
        m_tdata[41:27] = out_res_reg.beeper_now;
        m_tdata[42]    = out_res_reg.clock_switch_event;
        m_tdata[44:43] = out_res_reg.machine_mode;
    end

endmodule

`default_nettype wire
